// ===== src/m3i_pkg.sv =====
// Shared types and widths for the 3x3 matrix inverse core.
package m3i_pkg;

    localparam int DW   = 32;
    localparam int PW   = 2 * DW;
    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int RW   = DETW + DW;

    typedef struct packed {
        logic signed [DW-1:0] a11;
        logic signed [DW-1:0] a12;
        logic signed [DW-1:0] a13;
        logic signed [DW-1:0] a21;
        logic signed [DW-1:0] a22;
        logic signed [DW-1:0] a23;
        logic signed [DW-1:0] a31;
        logic signed [DW-1:0] a32;
        logic signed [DW-1:0] a33;
    } m3i_in_t;

    typedef struct packed {
        logic signed [DW-1:0] inv11;
        logic signed [DW-1:0] inv12;
        logic signed [DW-1:0] inv13;
        logic signed [DW-1:0] inv21;
        logic signed [DW-1:0] inv22;
        logic signed [DW-1:0] inv23;
        logic signed [DW-1:0] inv31;
        logic signed [DW-1:0] inv32;
        logic signed [DW-1:0] inv33;
        logic                 singular;
        logic                 saturated;
    } m3i_out_t;

    typedef struct packed {
        logic [8:0][CW-1:0] cof;
        logic [DETW-1:0]    det;
        m3i_in_t            mat;
    } m3i_work_t;

endpackage

// ===== src/matrix3x3_inverse_core.sv =====
// Top level of the 3x3 matrix inverse core.
//
// Input: raise start with one matrix of nine signed Q16.16 entries; the
// transaction is taken at a rising edge where start is high and busy is low.
// Output: valid pulses for one cycle with the inverse, the singular flag
// (input echoed when the determinant is zero) and the saturated flag.
// The receiver cannot stall; every result must be taken in its cycle.
// Throughput: one matrix per cycle. busy rises only if the two-entry queue
// between the cofactor front end and the divider back end fills.
// Path: the cofactor and determinant pipeline, the queue, a sign and range
// check stage, 32 divider stages (one quotient bit each, nine lanes in
// parallel) and the output register.
// Reset clears all valid bits and queue pointers; no result is issued
// until a new transaction is accepted.
module matrix3x3_inverse_core
    import m3i_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  m3i_in_t  matrix,
    output logic     busy,
    output logic     valid,
    output m3i_out_t result
);

    logic      push, full, empty;
    m3i_work_t fwork, qwork;

    m3i_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .matrix (matrix),
        .busy   (busy),
        .push   (push),
        .work   (fwork),
        .full   (full)
    );

    m3i_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (fwork),
        .full  (full),
        .pop   (!empty),
        .empty (empty),
        .rdata (qwork)
    );

    m3i_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!empty),
        .work     (qwork),
        .valid    (valid),
        .result   (result)
    );

endmodule

// ===== src/m3i_front.sv =====
// Front end: exact cofactors and determinant, pipelined over four stages.
module m3i_front
    import m3i_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  m3i_in_t   matrix,
    output logic      busy,
    output logic      push,
    output m3i_work_t work,
    input  logic      full
);

    localparam int PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int NA [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int NB [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DW-1:0]  a [9];
    logic signed [DW-1:0]  a2 [9];
    logic signed [PW-1:0]  pp_reg [9];
    logic signed [PW-1:0]  pn_reg [9];
    logic signed [CW-1:0]  c_reg [9];
    logic signed [CW-1:0]  c3_reg [9];
    logic signed [CW-1:0]  pl_reg [3];
    logic signed [CW-1:0]  ph_reg [3];
    logic signed [DW:0]    lo_s [3];
    logic signed [DW:0]    hi_s [3];
    logic signed [DW-1:0]  x [3];
    logic signed [DETW-1:0] det_next;
    m3i_in_t m1_reg, m2_reg, m3_reg;
    m3i_work_t work_reg;

    assign adv  = !v4_reg || !full;
    assign busy = !adv;
    assign push = v4_reg && !full;
    assign work = work_reg;

    always_comb
    begin
        a[0] = matrix.a11; a[1] = matrix.a12; a[2] = matrix.a13;
        a[3] = matrix.a21; a[4] = matrix.a22; a[5] = matrix.a23;
        a[6] = matrix.a31; a[7] = matrix.a32; a[8] = matrix.a33;
        a2[0] = m2_reg.a11; a2[1] = m2_reg.a12; a2[2] = m2_reg.a13;
        a2[3] = m2_reg.a21; a2[4] = m2_reg.a22; a2[5] = m2_reg.a23;
        a2[6] = m2_reg.a31; a2[7] = m2_reg.a32; a2[8] = m2_reg.a33;
        x[0] = a2[0];
        x[1] = a2[3];
        x[2] = a2[6];
        for (int j = 0; j < 3; j++)
        begin
            lo_s[j] = $signed({1'b0, c_reg[j][DW-1:0]});
            hi_s[j] = $signed(c_reg[j][CW-1:DW]);
        end
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + DETW'($signed({ph_reg[j], {DW{1'b0}}}))
                                + DETW'(pl_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
            begin
                pp_reg[k] <= a[PA[k]] * a[PB[k]];
                pn_reg[k] <= a[NA[k]] * a[NB[k]];
                c_reg[k]  <= CW'(pp_reg[k]) - CW'(pn_reg[k]);
                c3_reg[k] <= c_reg[k];
                work_reg.cof[k] <= c3_reg[k];
            end
            for (int j = 0; j < 3; j++)
            begin
                pl_reg[j] <= x[j] * lo_s[j];
                ph_reg[j] <= x[j] * hi_s[j];
            end
            m1_reg <= matrix;
            m2_reg <= m1_reg;
            m3_reg <= m2_reg;
            work_reg.det <= det_next;
            work_reg.mat <= m3_reg;
        end
    end

endmodule

// ===== src/m3i_queue.sv =====
// Two-entry queue between the front end and the divider back end.
module m3i_queue
    import m3i_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  m3i_work_t wdata,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output m3i_work_t rdata
);

    m3i_work_t  mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== src/m3i_back.sv =====
// Back end: nine pipelined restoring dividers with saturation and output register.
module m3i_back
    import m3i_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  m3i_work_t work,
    output logic      valid,
    output m3i_out_t  result
);

    localparam int NS = DW;

    logic [NS:0]      v_reg;
    logic [RW-1:0]    r_reg [NS+1][9];
    logic [DETW-1:0]  d_reg [NS+1];
    logic [DW-1:0]    q_reg [NS+1][9];
    logic [8:0]       neg_reg [NS+1];
    logic [8:0]       big_reg [NS+1];
    logic             sing_reg [NS+1];
    m3i_in_t          mat_reg [NS+1];

    logic [DETW-1:0]  dabs;
    logic [CW-1:0]    cabs [9];
    logic [RW-1:0]    r0 [9];
    logic [RW-1:0]    dsh0;
    logic [8:0]       big0, neg0;
    logic [RW-1:0]    shv [1:NS];
    logic [RW-1:0]    rn [1:NS][9];
    logic [DW-1:0]    qn [1:NS][9];
    logic             ge;

    logic [DW-1:0]    half, maxv;
    logic [DW-1:0]    val [9];
    logic [8:0]       sat;
    m3i_out_t         res_next, res_reg;
    logic             valid_reg;

    always_comb
    begin
        dabs = work.det[DETW-1] ? DETW'(-$signed(work.det)) : work.det;
        dsh0 = RW'(dabs) << DW;
        for (int i = 0; i < 9; i++)
        begin
            cabs[i] = work.cof[i][CW-1] ? CW'(-$signed(work.cof[i])) : work.cof[i];
            r0[i]   = RW'(cabs[i]) << (2 * FRAC_BITS);
            big0[i] = r0[i] >= dsh0;
            neg0[i] = work.cof[i][CW-1] ^ work.det[DETW-1];
        end
    end

    always_comb
    begin
        for (int s = 1; s <= NS; s++)
        begin
            shv[s] = RW'(d_reg[s-1]) << (NS - s);
            for (int i = 0; i < 9; i++)
            begin
                ge = r_reg[s-1][i] >= shv[s];
                rn[s][i] = ge ? r_reg[s-1][i] - shv[s] : r_reg[s-1][i];
                qn[s][i] = q_reg[s-1][i] | (ge ? (DW'(1) << (NS - s)) : DW'(0));
            end
        end
    end

    always_comb
    begin
        half = DW'(1) << (DW - 1);
        maxv = half - DW'(1);
        for (int i = 0; i < 9; i++)
        begin
            if (neg_reg[NS][i])
            begin
                sat[i] = big_reg[NS][i] || (q_reg[NS][i] > half);
                val[i] = sat[i] ? half : DW'(-q_reg[NS][i]);
            end
            else
            begin
                sat[i] = big_reg[NS][i] || (q_reg[NS][i] > maxv);
                val[i] = sat[i] ? maxv : q_reg[NS][i];
            end
        end
        if (sing_reg[NS])
        begin
            res_next.inv11 = mat_reg[NS].a11;
            res_next.inv12 = mat_reg[NS].a12;
            res_next.inv13 = mat_reg[NS].a13;
            res_next.inv21 = mat_reg[NS].a21;
            res_next.inv22 = mat_reg[NS].a22;
            res_next.inv23 = mat_reg[NS].a23;
            res_next.inv31 = mat_reg[NS].a31;
            res_next.inv32 = mat_reg[NS].a32;
            res_next.inv33 = mat_reg[NS].a33;
            res_next.singular  = 1'b1;
            res_next.saturated = 1'b0;
        end
        else
        begin
            res_next.inv11 = val[0];
            res_next.inv12 = val[1];
            res_next.inv13 = val[2];
            res_next.inv21 = val[3];
            res_next.inv22 = val[4];
            res_next.inv23 = val[5];
            res_next.inv31 = val[6];
            res_next.inv32 = val[7];
            res_next.inv33 = val[8];
            res_next.singular  = 1'b0;
            res_next.saturated = |sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            v_reg     <= {v_reg[NS-1:0], in_valid};
            valid_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0]    <= dabs;
        neg_reg[0]  <= neg0;
        big_reg[0]  <= big0;
        sing_reg[0] <= work.det == '0;
        mat_reg[0]  <= work.mat;
        for (int i = 0; i < 9; i++)
        begin
            r_reg[0][i] <= r0[i];
            q_reg[0][i] <= '0;
        end
        for (int s = 1; s <= NS; s++)
        begin
            d_reg[s]    <= d_reg[s-1];
            neg_reg[s]  <= neg_reg[s-1];
            big_reg[s]  <= big_reg[s-1];
            sing_reg[s] <= sing_reg[s-1];
            mat_reg[s]  <= mat_reg[s-1];
            for (int i = 0; i < 9; i++)
            begin
                r_reg[s][i] <= rn[s][i];
                q_reg[s][i] <= qn[s][i];
            end
        end
        res_reg <= res_next;
    end

    assign valid  = valid_reg;
    assign result = res_reg;

endmodule

// ===== tb/sv/m3i_checker.sv =====
`timescale 1ns / 1ps
// Checker for the 3x3 matrix inverse core: predicts each inverse and compares results.
module m3i_checker
    import m3i_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  m3i_in_t  matrix,
    input  logic     valid,
    input  m3i_out_t result,
    output int       errors,
    output int       pending
);

    localparam int FB = 16;

    m3i_out_t inverse_q[$];

    function automatic logic signed [DW-1:0] div_sat(logic signed [255:0] cof,
                                                     logic signed [255:0] det,
                                                     ref logic sat);
        logic signed [255:0] num;
        logic signed [255:0] q;
        logic signed [255:0] hi;
        logic signed [255:0] lo;
        begin
            num = cof <<< (2 * FB);
            q   = num / det;
            hi  = (256'sd1 <<< (DW - 1)) - 1;
            lo  = -(256'sd1 <<< (DW - 1));
            if (q > hi)
            begin
                sat = 1'b1;
                return hi[DW-1:0];
            end
            if (q < lo)
            begin
                sat = 1'b1;
                return lo[DW-1:0];
            end
            return q[DW-1:0];
        end
    endfunction

    function automatic m3i_out_t predict_inverse(m3i_in_t m);
        logic signed [255:0] a [9];
        logic signed [255:0] c [9];
        logic signed [255:0] det;
        logic signed [DW-1:0] e [9];
        logic sat;
        m3i_out_t r;
        begin
            a[0] = m.a11; a[1] = m.a12; a[2] = m.a13;
            a[3] = m.a21; a[4] = m.a22; a[5] = m.a23;
            a[6] = m.a31; a[7] = m.a32; a[8] = m.a33;
            det = a[0]*a[4]*a[8] + a[3]*a[7]*a[2] + a[6]*a[1]*a[5]
                - a[0]*a[7]*a[5] - a[6]*a[4]*a[2] - a[3]*a[1]*a[8];
            r = '0;
            if (det == 0)
            begin
                r.inv11 = m.a11; r.inv12 = m.a12; r.inv13 = m.a13;
                r.inv21 = m.a21; r.inv22 = m.a22; r.inv23 = m.a23;
                r.inv31 = m.a31; r.inv32 = m.a32; r.inv33 = m.a33;
                r.singular = 1'b1;
                return r;
            end
            c[0] = a[4]*a[8] - a[5]*a[7];
            c[1] = a[2]*a[7] - a[1]*a[8];
            c[2] = a[1]*a[5] - a[2]*a[4];
            c[3] = a[5]*a[6] - a[3]*a[8];
            c[4] = a[0]*a[8] - a[2]*a[6];
            c[5] = a[2]*a[3] - a[0]*a[5];
            c[6] = a[3]*a[7] - a[4]*a[6];
            c[7] = a[1]*a[6] - a[0]*a[7];
            c[8] = a[0]*a[4] - a[1]*a[3];
            sat = 1'b0;
            for (int i = 0; i < 9; i++)
                e[i] = div_sat(c[i], det, sat);
            r.inv11 = e[0]; r.inv12 = e[1]; r.inv13 = e[2];
            r.inv21 = e[3]; r.inv22 = e[4]; r.inv23 = e[5];
            r.inv31 = e[6]; r.inv32 = e[7]; r.inv33 = e[8];
            r.saturated = sat;
            return r;
        end
    endfunction

    assign pending = inverse_q.size();

    initial errors = 0;

    always @(posedge clk)
    begin
        m3i_out_t exp_r;
        if (rst_n)
        begin
            if (start && !busy)
                inverse_q.push_back(predict_inverse(matrix));
            if (valid)
            begin
                if (inverse_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", result);
                end
                else
                begin
                    exp_r = inverse_q.pop_front();
                    if (exp_r !== result)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h actual %h", exp_r, result);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_matrix3x3_inverse_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the 3x3 matrix inverse core: stimulus, watchdog and verdict.
module tb_matrix3x3_inverse_core;
    import m3i_pkg::*;

    localparam int LATENCY = 39;
    localparam int WATCHDOG = 2000;

    logic     clk;
    logic     rst_n;
    logic     start;
    m3i_in_t  matrix;
    logic     busy;
    logic     valid;
    m3i_out_t result;
    int       errors;
    int       pending;
    int       idle_pct;
    int       stall;

    matrix3x3_inverse_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .matrix (matrix),
        .busy   (busy),
        .valid  (valid),
        .result (result)
    );

    m3i_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .matrix  (matrix),
        .valid   (valid),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && !((start && !busy) || valid))
            stall <= stall + 1;
        else
            stall <= 0;
    end

    always @(posedge clk)
    begin
        if (stall >= WATCHDOG)
        begin
            $display("tb_matrix3x3_inverse_core NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] pick_entry(int kind);
        case (kind)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            4: return 32'hFFFF_0000;
            5: return 32'h0000_0001;
            6: return 32'hFFFF_FFFF;
            7: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send(m3i_in_t m);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        matrix <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random(int n);
        m3i_in_t m;
        int mode;
        for (int i = 0; i < n; i++)
        begin
            mode = $urandom_range(0, 9);
            m = {9{32'h0}};
            m.a11 = pick_entry(mode < 5 ? 7 : $urandom_range(0, 8));
            m.a12 = pick_entry(mode < 5 ? 7 : $urandom_range(0, 8));
            m.a13 = pick_entry(mode < 5 ? 7 : $urandom_range(0, 8));
            m.a21 = pick_entry(mode < 5 ? 7 : $urandom_range(0, 8));
            m.a22 = pick_entry(mode < 5 ? 7 : $urandom_range(0, 8));
            m.a23 = pick_entry(mode < 5 ? 7 : $urandom_range(0, 8));
            m.a31 = pick_entry(mode < 5 ? 7 : $urandom_range(0, 8));
            m.a32 = pick_entry(mode < 5 ? 7 : $urandom_range(0, 8));
            m.a33 = pick_entry(mode < 5 ? 7 : $urandom_range(0, 8));
            if (mode == 9)
            begin
                m.a31 = m.a11;
                m.a32 = m.a12;
                m.a33 = m.a13;
            end
            send(m);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        matrix   = '0;
        idle_pct = 0;
        stall    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send({32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0,
              32'h0, 32'h0, 32'h0001_0000});
        send({32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'hFFFE_0000, 32'h0,
              32'h0, 32'h0, 32'h0000_8000});
        send({9{32'h0}});
        send({9{32'h8000_0000}});
        send({9{32'h7FFF_FFFF}});
        send({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1});
        send({32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0,
              32'h0, 32'h0, 32'h7FFF_FFFF});
        send({32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF});
        send({32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
              32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000,
              32'h000A_0000});
        send({32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
              32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000,
              32'h0009_0000});
        send({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0,
              32'h0, 32'h0, 32'hFFFF_FFFF});

        idle_pct = 6;
        send_random(230);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        idle_pct = 64;
        send_random(230);
        idle_pct = 0;
        send_random(230);
        start <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("tb_matrix3x3_inverse_core OK");
        else
            $display("tb_matrix3x3_inverse_core NOT OK");
        $finish;
    end

endmodule
